// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define TVC_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define TVC_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define TVC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/tvc_pkg.sv -----
// ---------------------------------------------------------------------------
// Triangle vertex transform package
// Types, codes, reset values and helpers shared by the transform blocks.
// ---------------------------------------------------------------------------
`default_nettype none

package tvc_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [30:0] NEAR_PLANE_RST   = 31'd6554;
    localparam logic [30:0] FAR_PLANE_RST    = 31'd6553600;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_NEAR_PLANE   = 2'd2;
    localparam logic [1:0] REG_FAR_PLANE    = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD_VP,
        OP_LOAD_M,
        OP_VERTEX,
        OP_NONE
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LO,
        S_HI,
        S_SUM,
        S_ACC,
        S_XFER,
        S_CULL,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        D_IDLE,
        D_CHECK,
        D_ITER,
        D_ROUND,
        D_FIN
    } t_div_state;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tvc_mul.sv -----
// ---------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 multiplier with a registered product.
// ---------------------------------------------------------------------------
`default_nettype none

module tvc_mul
    import tvc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_prod;

endmodule

`default_nettype wire

// ----- rtl/tvc_div.sv -----
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring divider with rounding half away from zero and 32-bit saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module tvc_div
    import tvc_pkg::*;
#(
    parameter int NW = FRAC_BITS_DEF + COORD_WIDTH_DEF + 14,
    parameter int DW = COORD_WIDTH_DEF + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_neg,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic        [31:0] o_quot
);

    localparam int XW = (NW > DW + 34) ? NW : DW + 34;
    localparam logic [33:0] Q_SAT = 34'h2_0000_0000;

    t_div_state       r_state;
    t_div_state       n_state;
    logic [XW-1:0]    r_rem;
    logic [XW-1:0]    r_dsh;
    logic [DW-1:0]    r_den;
    logic [33:0]      r_q;
    logic [5:0]       r_cnt;
    logic             r_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) n_state = D_CHECK;
            end
            D_CHECK: begin
                if (r_den == '0 || r_rem >= r_dsh) n_state = D_FIN;
                else n_state = D_ITER;
            end
            D_ITER: begin
                if (r_cnt == 6'd1) n_state = D_ROUND;
            end
            D_ROUND: begin
                n_state = D_FIN;
            end
            D_FIN: begin
                o_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                r_rem <= XW'(i_num);
                r_den <= i_den;
                r_dsh <= XW'(i_den) << 33;
                r_neg <= i_neg;
            end
            D_CHECK: begin
                if (r_den == '0) begin
                    r_q <= (r_rem == '0) ? 34'd0 : Q_SAT;
                end else if (r_rem >= r_dsh) begin
                    r_q <= Q_SAT;
                end else begin
                    r_q   <= 34'd0;
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= 6'd33;
                end
            end
            D_ITER: begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[32:0], 1'b1};
                end else begin
                    r_q   <= {r_q[32:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 6'd1;
            end
            D_ROUND: begin
                if ((r_rem << 1) >= XW'(r_den)) r_q <= r_q + 34'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (r_neg) begin
            o_quot = (r_q > 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-r_q);
        end else begin
            o_quot = (r_q > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_q[31:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/triangle_vertex_transform_cull.sv -----
// ---------------------------------------------------------------------------
// Triangle vertex transform and cull
// Transforms vertices by model and view-projection matrices, rejects trivially
// invisible triangles and maps kept triangles to the viewport.
// ---------------------------------------------------------------------------
// Items arrive on the s_axis channel; tuser carries the operation code.
// Load transfers write one matrix coefficient.
// A vertex transfer runs two 4x4 matrix-vector products term by term
// through one shared 32x32 multiplier, each term in states S_LO, S_HI,
// S_SUM and S_ACC. The third vertex of a triangle adds the cull check and,
// for a kept triangle, nine divides on one iterative divider and six
// viewport scale products, after which the result leaves on m_axis.
// The input is not ready while an item is in work.
// The result sits in an output register, so a new item is accepted while the
// receiver stalls; the block waits only when a second result is ready.
// Reset restores identity matrices, the default viewport and planes, and
// restarts the vertex count. Configuration is written over the APB port.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_vertex_transform_cull
    import tvc_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // coef_index, coef_value, pos_x, pos_y, pos_z, zero fill
    input  wire logic [135:0] s_axis_tdata,
    // op
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // screen_x_a, screen_y_a, depth_a, screen_x_b, screen_y_b, depth_b,
    // screen_x_c, screen_y_c, depth_c
    output logic      [287:0] m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    `include "assert_macros.svh"

    localparam int CW = COORD_WIDTH;
    localparam int VW = (CW > 32) ? CW : 32;
    localparam int NW = FRAC_BITS + CW + 14;
    localparam int DW = (CW + 1 > 31) ? CW + 1 : 31;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [59:0] MAXC = (60'sd1 <<< (CW - 1)) - 60'sd1;
    localparam logic signed [59:0] MINC = -MAXC - 60'sd1;

    t_state r_state;
    t_state n_state;

    logic signed [31:0]   r_vp [16];
    logic signed [31:0]   r_m [16];
    logic [1:0]           r_vcnt;
    logic [12:0]          r_fw;
    logic [12:0]          r_fh;
    logic [30:0]          r_near;
    logic [30:0]          r_far;
    logic signed [VW-1:0] r_vec [4];
    logic signed [CW-1:0] r_res [4];
    logic signed [CW-1:0] r_clip [3][4];
    logic                 r_pass;
    logic [1:0]           r_row;
    logic [1:0]           r_col;
    logic                 r_map;
    logic [1:0]           r_k;
    logic [1:0]           r_axis;
    logic                 r_neg;
    logic [63:0]          r_plo;
    logic [95:0]          r_full;
    logic signed [59:0]   r_acc;
    logic [31:0]          r_q [9];
    logic                 r_out_valid;
    logic [287:0]         r_out_data;

    logic                 in_fire;
    t_op                  in_op;
    logic [3:0]           in_idx;
    logic signed [31:0]   in_coef;
    logic signed [31:0]   coef_sel;
    logic [63:0]          coef_mag;
    logic [63:0]          vec_mag;
    logic signed [CW-1:0] clip_c;
    logic signed [CW-1:0] clip_w;
    logic signed [63:0]   map_num;
    logic [63:0]          map_mag;
    logic [12:0]          scale;
    logic [12:0]          scale_m1;
    logic [63:0]          b_mag;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [63:0]          mul_p;
    logic [95:0]          rnd;
    logic [95:0]          sh;
    logic [56:0]          term_mag;
    logic [59:0]          term_u;
    logic signed [59:0]   term_s;
    logic signed [59:0]   acc_n;
    logic signed [CW-1:0] acc_sat;
    logic                 cull;
    logic signed [63:0]   dep_num;
    logic signed [63:0]   dep_den;
    logic                 div_start;
    logic                 div_neg;
    logic [NW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic                 div_done;
    logic [31:0]          div_quot;
    logic                 out_load;
    logic                 cfg_wr;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign in_op   = t_op'(s_axis_tuser);
    assign in_idx  = s_axis_tdata[3:0];
    assign in_coef = s_axis_tdata[35:4];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = 32'(r_fw);
            REG_FRAME_HEIGHT: prdata = 32'(r_fh);
            REG_NEAR_PLANE:   prdata = 32'(r_near);
            REG_FAR_PLANE:    prdata = 32'(r_far);
            default:          prdata = 32'd0;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        coef_sel = r_pass ? r_vp[{r_col, r_row}] : r_m[{r_col, r_row}];
        coef_mag = mag64(64'(coef_sel));
        vec_mag  = mag64(64'(r_vec[r_col]));
        clip_c   = r_clip[r_k][r_axis];
        clip_w   = r_clip[r_k][3];
        map_num  = 64'(clip_c) + 64'(clip_w);
        map_mag  = mag64(map_num);
        scale    = (r_axis == 2'd0) ? r_fw : r_fh;
        scale_m1 = (scale == 13'd0) ? 13'd0 : scale - 13'd1;
        b_mag    = r_map ? map_mag : vec_mag;
        mul_a    = r_map ? 32'(scale_m1) : coef_mag[31:0];
        mul_b    = (r_state == S_LO) ? b_mag[31:0] : b_mag[63:32];
    end

    tvc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Rounded, capped and signed product term, then the row sum.
    always_comb begin
        rnd      = r_full + (96'd1 << (FRAC_BITS - 1));
        sh       = rnd >> FRAC_BITS;
        term_mag = (sh > (96'd1 << 56)) ? (57'd1 << 56) : sh[56:0];
        term_u   = {3'b000, term_mag};
        term_s   = r_neg ? -$signed(term_u) : $signed(term_u);
        acc_n    = r_acc + term_s;
        if (acc_n > MAXC) acc_sat = CW'(MAXC);
        else if (acc_n < MINC) acc_sat = CW'(MINC);
        else acc_sat = CW'(acc_n);
    end

    always_comb begin
        logic hi_all;
        logic lo_all;
        logic signed [CW:0] ce;
        logic signed [CW:0] we;
        cull = r_clip[0][3][CW-1] && r_clip[1][3][CW-1] && r_clip[2][3][CW-1];
        for (int a = 0; a < 3; a++) begin
            hi_all = 1'b1;
            lo_all = 1'b1;
            for (int k = 0; k < 3; k++) begin
                ce = {r_clip[k][a][CW-1], r_clip[k][a]};
                we = {r_clip[k][3][CW-1], r_clip[k][3]};
                if (!(ce > we)) hi_all = 1'b0;
                if (!(ce < -we)) lo_all = 1'b0;
            end
            if (hi_all || lo_all) cull = 1'b1;
        end
    end

    always_comb begin
        dep_num   = 64'(clip_w) - {33'd0, r_near};
        dep_den   = {33'd0, r_far} - {33'd0, r_near};
        div_start = (r_state == S_DIV_START);
        if (r_axis == 2'd2) begin
            div_num = NW'(mag64(dep_num)) << FRAC_BITS;
            div_den = DW'(mag64(dep_den));
            div_neg = dep_num[63] != dep_den[63];
        end else begin
            div_num = NW'(r_full) << FRAC_BITS;
            div_den = DW'(mag64(64'(clip_w))) << 1;
            div_neg = map_num[63] != clip_w[CW-1];
        end
    end

    tvc_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_neg   (div_neg),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && in_op == OP_VERTEX) n_state = S_LO;
            end
            S_LO: n_state = S_HI;
            S_HI: n_state = S_SUM;
            S_SUM: n_state = r_map ? S_DIV_START : S_ACC;
            S_ACC: begin
                if (r_col == 2'd3 && r_row == 2'd3) n_state = S_XFER;
                else n_state = S_LO;
            end
            S_XFER: begin
                if (!r_pass) n_state = S_LO;
                else if (r_vcnt == 2'd2) n_state = S_CULL;
                else n_state = S_IDLE;
            end
            S_CULL: n_state = cull ? S_IDLE : S_LO;
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    if (r_axis == 2'd2) n_state = (r_k == 2'd2) ? S_OUT : S_LO;
                    else if (r_axis == 2'd1) n_state = S_DIV_START;
                    else n_state = S_LO;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_vp[i] <= (i % 5 == 0) ? ONE : 32'sd0;
                r_m[i]  <= (i % 5 == 0) ? ONE : 32'sd0;
            end
            r_vcnt <= 2'd0;
        end else begin
            if (in_fire) begin
                case (in_op)
                    OP_LOAD_VP: begin
                        r_vp[in_idx] <= in_coef;
                        r_vcnt       <= 2'd0;
                    end
                    OP_LOAD_M: begin
                        r_m[in_idx] <= in_coef;
                        r_vcnt      <= 2'd0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_XFER && r_pass) begin
                r_vcnt <= (r_vcnt == 2'd2) ? 2'd0 : r_vcnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= FRAME_WIDTH_RST;
            r_fh   <= FRAME_HEIGHT_RST;
            r_near <= NEAR_PLANE_RST;
            r_far  <= FAR_PLANE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:  r_fw   <= pwdata[12:0];
                REG_FRAME_HEIGHT: r_fh   <= pwdata[12:0];
                REG_NEAR_PLANE:   r_near <= pwdata[30:0];
                REG_FAR_PLANE:    r_far  <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_vec[0] <= VW'($signed(s_axis_tdata[67:36]));
                r_vec[1] <= VW'($signed(s_axis_tdata[99:68]));
                r_vec[2] <= VW'($signed(s_axis_tdata[131:100]));
                r_vec[3] <= VW'(ONE);
                r_pass   <= 1'b0;
                r_map    <= 1'b0;
                r_row    <= 2'd0;
                r_col    <= 2'd0;
                r_acc    <= '0;
            end
            S_LO: begin
                r_neg <= coef_sel[31] != r_vec[r_col][VW-1];
            end
            S_HI: begin
                r_plo <= mul_p;
            end
            S_SUM: begin
                r_full <= {mul_p, 32'd0} + {32'd0, r_plo};
            end
            S_ACC: begin
                if (r_col == 2'd3) begin
                    r_res[r_row] <= acc_sat;
                    r_acc        <= '0;
                    r_col        <= 2'd0;
                    r_row        <= r_row + 2'd1;
                end else begin
                    r_acc <= acc_n;
                    r_col <= r_col + 2'd1;
                end
            end
            S_XFER: begin
                if (!r_pass) begin
                    for (int i = 0; i < 4; i++) r_vec[i] <= VW'(r_res[i]);
                    r_pass <= 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) r_clip[r_vcnt][i] <= r_res[i];
                end
            end
            S_CULL: begin
                r_map  <= 1'b1;
                r_k    <= 2'd0;
                r_axis <= 2'd0;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    r_q[4'(r_k) * 4'd3 + 4'(r_axis)] <= div_quot;
                    if (r_axis == 2'd2) begin
                        r_axis <= 2'd0;
                        r_k    <= r_k + 2'd1;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int i = 0; i < 9; i++) r_out_data[32*i +: 32] <= r_q[i];
        end
    end

    `TVC_ASSERT_ALWAYS(a_vcnt_range, r_vcnt != 2'd3)
    `TVC_ASSERT_IMPL(a_div_done_wait, div_done, r_state == S_DIV_WAIT)
    `TVC_ASSERT_NEXT(a_out_hold, (r_state == S_OUT) && r_out_valid && !m_axis_tready, r_state == S_OUT)

endmodule

`default_nettype wire

// ----- tb/tb_triangle_vertex_transform_cull.sv -----
// ---------------------------------------------------------------------------
// Triangle vertex transform and cull testbench
// Drives load, vertex and unused items on the input stream and writes the
// viewport and plane registers over APB between phases. A built-in predictor
// tracks both matrices, the held vertices and the registers, and each result
// transfer is checked field by field against the oldest predicted triangle.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_triangle_vertex_transform_cull;
    import tvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;
    localparam int CW = COORD_WIDTH_DEF;
    localparam longint ONE = 64'sd1 <<< FB;
    localparam int SETTLE = 600;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 4000;

    typedef struct {
        t_op         op;
        logic [3:0]  idx;
        logic [31:0] coef;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_vtx_item;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [287:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    triangle_vertex_transform_cull dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    t_vtx_item    item_q[$];
    t_vtx_item    on_bus;
    logic [287:0] triangle_q[$];

    longint       vp_mat[16];
    longint       model_mat[16];
    longint       held_clip[8];
    int           held_count;
    longint       width_reg, height_reg, near_reg, far_reg;

    int  errors = 0;
    int  idle_mode = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_cnt = 0;
    int  stall_cnt = 0;
    int  items_sent = 0;
    int  vertices_sent = 0;
    int  triangles_kept = 0;
    int  triangles_culled = 0;
    int  results_seen = 0;
    bit  in_taken = 0;
    bit  apb_busy = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [127:0] mag128(input longint v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic longint sat_coord(input longint v);
        longint mx;
        mx = (64'sd1 <<< (CW - 1)) - 1;
        return v > mx ? mx : (v < -mx - 1 ? -mx - 1 : v);
    endfunction

    function automatic longint fixed_mul(input longint a, input longint b);
        logic [127:0] p;
        p = (mag128(a) * mag128(b) + (128'd1 << (FB - 1))) >> FB;
        if (p > (128'd1 << 56))
            p = 128'd1 << 56;
        return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic void mat_vec(input longint mat[16], input longint v[4],
                                    output longint o[4]);
        longint acc;
        for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int c = 0; c < 4; c++)
                acc += fixed_mul(mat[c*4 + r], v[c]);
            o[r] = sat_coord(acc);
        end
    endfunction

    function automatic longint round_div(input bit neg, input logic [127:0] num,
                                         input logic [127:0] den);
        logic [127:0] q, r;
        if (den == 0)
            return num == 0 ? 0 : (neg ? -64'sd2147483648 : 64'sd2147483647);
        q = num / den;
        r = num % den;
        if (q > 128'hFFFF_FFFF_FFFF_FFFF)
            q = 128'hFFFF_FFFF_FFFF_FFFF;
        else if (r >= den - r && q != 128'hFFFF_FFFF_FFFF_FFFF)
            q = q + 1;
        if (neg) begin
            if (q > 128'h8000_0000)
                q = 128'h8000_0000;
            return -longint'(q[63:0]);
        end
        if (q > 128'h7FFF_FFFF)
            q = 128'h7FFF_FFFF;
        return longint'(q[63:0]);
    endfunction

    function automatic longint screen_coord(input longint c, input longint w,
                                            input longint size);
        longint num;
        longint span;
        span = size == 0 ? 0 : size - 1;
        num = c + w;
        return round_div((num < 0) != (w < 0), (mag128(num) * span) << FB,
                         2 * mag128(w));
    endfunction

    function automatic longint linear_depth(input longint w);
        longint num, den;
        num = w - near_reg;
        den = far_reg - near_reg;
        return round_div((num < 0) != (den < 0), mag128(num) << FB, mag128(den));
    endfunction

    task automatic predict_transfer(input t_vtx_item it);
        longint v[4], wv[4], cv[12], tmp[4];
        logic [287:0] res;
        bit cull, hi_all, lo_all;
        if (it.op == OP_LOAD_VP || it.op == OP_LOAD_M) begin
            if (it.op == OP_LOAD_VP)
                vp_mat[it.idx] = longint'($signed(it.coef));
            else
                model_mat[it.idx] = longint'($signed(it.coef));
            held_count = 0;
            return;
        end
        if (it.op != OP_VERTEX)
            return;
        vertices_sent++;
        v[0] = longint'($signed(it.x));
        v[1] = longint'($signed(it.y));
        v[2] = longint'($signed(it.z));
        v[3] = ONE;
        mat_vec(model_mat, v, wv);
        mat_vec(vp_mat, wv, tmp);
        if (held_count < 2) begin
            for (int a = 0; a < 4; a++)
                held_clip[held_count*4 + a] = tmp[a];
            held_count++;
            return;
        end
        held_count = 0;
        for (int a = 0; a < 8; a++)
            cv[a] = held_clip[a];
        for (int a = 0; a < 4; a++)
            cv[8 + a] = tmp[a];
        cull = 0;
        for (int a = 0; a < 3; a++) begin
            hi_all = 1;
            lo_all = 1;
            for (int k = 0; k < 3; k++) begin
                if (!(cv[k*4 + a] > cv[k*4 + 3])) hi_all = 0;
                if (!(cv[k*4 + a] < -cv[k*4 + 3])) lo_all = 0;
            end
            if (hi_all || lo_all) cull = 1;
        end
        if (cv[3] < 0 && cv[7] < 0 && cv[11] < 0) cull = 1;
        if (cull) begin
            triangles_culled++;
            return;
        end
        for (int k = 0; k < 3; k++) begin
            res[k*96 +: 32]      = 32'(screen_coord(cv[k*4], cv[k*4 + 3], width_reg));
            res[k*96 + 32 +: 32] = 32'(screen_coord(cv[k*4 + 1], cv[k*4 + 3], height_reg));
            res[k*96 + 64 +: 32] = 32'(linear_depth(cv[k*4 + 3]));
        end
        triangles_kept++;
        triangle_q = {triangle_q, res};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Input side: tvalid, tdata and tuser change at the falling edge.
    always @(negedge i_clk) begin
        bit idle;
        t_vtx_item nxt;
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            idle = (idle_mode == 0) ? ($urandom_range(0, 99) < 35) :
                   (idle_mode == 1) ? ($urandom_range(0, 99) < 70) : 1'b0;
            if (item_q.size() > 0 && !idle) begin
                nxt = item_q.pop_front();
                on_bus <= nxt;
                s_axis_tdata <= {4'd0, nxt.z, nxt.y, nxt.x, nxt.coef, nxt.idx};
                s_axis_tuser <= nxt.op;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: tready, with a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else if (idle_mode == 0) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 70);
        end else if (idle_mode == 1) begin
            m_axis_tready <= ($urandom_range(0, 99) >= 35);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [287:0] want;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            items_sent++;
            predict_transfer(on_bus);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (triangle_q.size() == 0) begin
                report_mismatch("unexpected result transfer", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = triangle_q.pop_front();
                for (int f = 0; f < 9; f++)
                    if (m_axis_tdata[f*32 +: 32] !== want[f*32 +: 32])
                        report_mismatch($sformatf("result field %0d", f),
                                        m_axis_tdata[f*32 +: 32], want[f*32 +: 32]);
            end
        end
        if (in_taken || (m_axis_tvalid && m_axis_tready) || apb_busy || !i_rst_n)
            stall_cnt = 0;
        else
            stall_cnt++;
    end

    always @(posedge i_clk) begin
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_item(input t_op op, input logic [3:0] idx, input logic [31:0] coef,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        t_vtx_item it;
        it.op = op;
        it.idx = idx;
        it.coef = coef;
        it.x = x;
        it.y = y;
        it.z = z;
        item_q = {item_q, it};
    endtask

    task automatic push_vertex(input longint x, input longint y, input longint z);
        push_item(OP_VERTEX, 4'($urandom), $urandom, 32'(x), 32'(y), 32'(z));
    endtask

    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        return 32'($urandom_range(0, 196608)) - 32'd98304;
    endfunction

    function automatic logic [31:0] rand_coef(input int idx);
        logic [31:0] c;
        if ($urandom_range(0, 19) == 0)
            return $urandom;
        if (idx % 5 == 0) begin
            c = $urandom_range(32768, 131072);
            return ($urandom_range(0, 7) == 0) ? -c : c;
        end
        return 32'($urandom_range(0, 32768)) - 32'd16384;
    endfunction

    task automatic apb_write(input logic [1:0] reg_sel, input logic [31:0] value);
        @(negedge i_clk);
        apb_busy = 1;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        apb_busy = 0;
        case (reg_sel)
            REG_FRAME_WIDTH:  width_reg = value & 32'h1FFF;
            REG_FRAME_HEIGHT: height_reg = value & 32'h1FFF;
            REG_NEAR_PLANE:   near_reg = value & 32'h7FFF_FFFF;
            REG_FAR_PLANE:    far_reg = value & 32'h7FFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic drain(input bit settle);
        while (item_q.size() != 0 || s_axis_tvalid || triangle_q.size() != 0)
            @(posedge i_clk);
        if (settle)
            repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < 16; i++) begin
            vp_mat[i] = (i % 5 == 0) ? ONE : 0;
            model_mat[i] = vp_mat[i];
        end
        for (int i = 0; i < 8; i++)
            held_clip[i] = 0;
        held_count = 0;
        width_reg = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        near_reg = NEAR_PLANE_RST;
        far_reg = FAR_PLANE_RST;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: kept triangle, plane reject, negative w, restarts, zero w,
        // unused op and saturating extremes.
        idle_mode = 2;
        push_vertex(0, 0, 0);
        push_vertex(ONE / 2, -ONE / 2, ONE / 4);
        push_vertex(-ONE / 2, ONE / 2, -ONE / 4);
        push_vertex(2 * ONE, 0, 0);
        push_vertex(3 * ONE, ONE / 2, 0);
        push_vertex(5 * ONE, -ONE / 2, 0);
        push_item(OP_LOAD_VP, 4'd15, 32'(-ONE), '0, '0, '0);
        push_vertex(0, 0, 0);
        push_vertex(ONE / 4, 0, 0);
        push_vertex(0, ONE / 4, 0);
        push_vertex(ONE / 8, 0, 0);
        push_item(OP_LOAD_VP, 4'd15, 32'd0, '0, '0, '0);
        push_vertex(ONE, 0, 0);
        push_item(OP_NONE, 4'hF, 32'hFFFF_FFFF, '1, '1, '1);
        push_vertex(-ONE, 0, 0);
        push_vertex(0, 0, 0);
        push_item(OP_LOAD_M, 4'd0, 32'h7FFF_FFFF, '0, '0, '0);
        push_item(OP_LOAD_VP, 4'd15, 32'(ONE), '0, '0, '0);
        push_vertex(64'h7FFF_FFFF, 64'h8000_0000, 64'h7FFF_FFFF);
        push_vertex(64'h8000_0000, 64'h7FFF_FFFF, 64'h8000_0000);
        push_vertex(0, 0, 0);
        push_item(OP_LOAD_M, 4'd15, 32'h8000_0000, '0, '0, '0);
        push_item(OP_LOAD_M, 4'd0, 32'(ONE), '0, '0, '0);
        push_item(OP_LOAD_M, 4'd15, 32'(ONE), '0, '0, '0);
        drain(1);

        for (int ph = 0; ph < 6; ph++) begin
            idle_mode = ph / 2;
            case (ph)
                1: begin
                    apb_write(REG_FRAME_WIDTH, 32'd4096);
                    apb_write(REG_FRAME_HEIGHT, 32'd1);
                    apb_write(REG_NEAR_PLANE, 32'd0);
                    apb_write(REG_FAR_PLANE, 32'h7FFF_FFFF);
                end
                2: begin
                    apb_write(REG_FRAME_WIDTH, 32'd1);
                    apb_write(REG_FRAME_HEIGHT, 32'd4096);
                    apb_write(REG_NEAR_PLANE, 32'h7FFF_FFFF);
                    apb_write(REG_FAR_PLANE, 32'd0);
                end
                3: begin
                    apb_write(REG_FRAME_WIDTH, 32'd0);
                    apb_write(REG_FRAME_HEIGHT, 32'hFFFF_FFFF);
                    apb_write(REG_NEAR_PLANE, 32'd65536);
                    apb_write(REG_FAR_PLANE, 32'd65536);
                end
                4, 5: begin
                    apb_write(REG_FRAME_WIDTH, $urandom_range(1, 4096));
                    apb_write(REG_FRAME_HEIGHT, $urandom_range(1, 4096));
                    apb_write(REG_NEAR_PLANE, $urandom_range(0, 65536));
                    apb_write(REG_FAR_PLANE, $urandom_range(131072, 32'h7FFF_FFFF));
                end
                default: ;
            endcase
            for (int i = 0; i < 16; i++) begin
                push_item(OP_LOAD_VP, 4'(i), rand_coef(i), $urandom, $urandom, $urandom);
                push_item(OP_LOAD_M, 4'(i), rand_coef(i), $urandom, $urandom, $urandom);
            end
            if (ph == 1)
                hold_req++;
            for (int n = 0; n < 40; n++) begin
                if (ph == 3 && n == 20)
                    drain(0);
                for (int k = 0; k < 3; k++) begin
                    if ($urandom_range(0, 29) == 0)
                        push_item(t_op'($urandom_range(0, 3)), 4'($urandom), $urandom,
                                  $urandom, $urandom, $urandom);
                    else
                        push_item(OP_VERTEX, 4'($urandom), $urandom,
                                  rand_pos(), rand_pos(), rand_pos());
                end
            end
            drain(1);
        end

        $display("Sent %0d items (%0d vertices) over six register settings.",
                 items_sent, vertices_sent);
        $display("Kept %0d triangles, culled %0d, checked %0d results.",
                 triangles_kept, triangles_culled, results_seen);
        if (errors == 0 && triangle_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
